@@ rtl/mqttp_pkg.sv @@
`timescale 1ns / 1ps

package mqttp_pkg;

   // Parse phase of the byte tracker.
   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_LEN     = 3'd1,
      PH_TLEN_HI = 3'd2,
      PH_TLEN_LO = 3'd3,
      PH_TOPIC   = 3'd4,
      PH_ID      = 3'd5,
      PH_BODY    = 3'd6,
      PH_BAD     = 3'd7
   } phase_type;

   // Byte region tags.
   localparam logic [2:0] REGION_HEADER    = 3'd0;
   localparam logic [2:0] REGION_LENGTH    = 3'd1;
   localparam logic [2:0] REGION_TOPIC_LEN = 3'd2;
   localparam logic [2:0] REGION_TOPIC     = 3'd3;
   localparam logic [2:0] REGION_PACKET_ID = 3'd4;
   localparam logic [2:0] REGION_PAYLOAD   = 3'd5;
   localparam logic [2:0] REGION_BEYOND    = 3'd6;

   // Parse status codes.
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_TOPIC_TRUNC   = 3'd1;
   localparam logic [2:0] STATUS_PAYLOAD_TRUNC = 3'd2;
   localparam logic [2:0] STATUS_NOT_PUBLISH   = 3'd3;
   localparam logic [2:0] STATUS_MALFORMED     = 3'd4;

   // Control packet types.
   localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
   localparam logic [3:0] TYPE_PUBACK   = 4'd4;
   localparam logic [3:0] TYPE_SUBACK   = 4'd9;
   localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

   localparam int REM_W = 28;

   function automatic logic is_ack_type(input logic [3:0] t);
      return ((t >= TYPE_PUBACK) && (t <= TYPE_SUBACK)) || (t == TYPE_UNSUBACK);
   endfunction

   // Tracker take enable and the load enables of the three pipeline stages.
   typedef struct packed {
      logic take;
      logic load_s1;
      logic load_s2;
      logic load_s3;
   } pipe_ctl_type;

   // Tracker state as it stands after one byte, before the end-of-buffer clear.
   typedef struct packed {
      logic [2:0]       region;
      logic             last;
      logic [7:0]       first;
      phase_type        phase;
      logic [REM_W-1:0] rem;
      logic [2:0]       vc;
      logic [15:0]      tsize;
      logic [15:0]      tstart;
      logic [15:0]      id;
      logic             lob;
   } snap_type;

   // Narrow part of the middle summary stage.
   typedef struct packed {
      logic [2:0]  region;
      logic        last;
      logic        bad;
      logic        pub;
      logic [1:0]  qos;
      logic [3:0]  msg_type;
      logic [15:0] tstart;
      logic [15:0] tsize;
      logic [15:0] id;
      logic        ack_ok;
   } mid_type;

endpackage

@@ rtl/mqttp_track.sv @@
`timescale 1ns / 1ps

module mqttp_track import mqttp_pkg::*; #(
   parameter int MAX_VARINT_BYTES = 4,
   parameter int OFFSET_BITS      = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output snap_type             snap,
   output logic [OFFSET_BITS:0] buf_len
);

   localparam int         LW     = OFFSET_BITS + 1;
   localparam int         KW     = (OFFSET_BITS > 28) ? OFFSET_BITS + 1 : 29;
   localparam logic [2:0] MAX_VC = 3'(MAX_VARINT_BYTES);

   logic [OFFSET_BITS-1:0] idx_ff, idx_in;
   logic [7:0]             first_ff, first_in, first_st;
   phase_type              phase_ff, phase_in, phase_st;
   logic [REM_W-1:0]       rem_ff, rem_in, rem_st;
   logic [2:0]             vc_ff, vc_in, vc_st;
   logic [15:0]            tsize_ff, tsize_in, tsize_st;
   logic [15:0]            tstart_ff, tstart_in, tstart_st;
   logic [15:0]            rc_ff, rc_in, rc_st;
   logic [15:0]            id_ff, id_in, id_st;
   logic                   lob_ff, lob_in, lob_st;
   logic [2:0]             region_st;

   snap_type               snap_ff;
   logic [LW-1:0]          len_ff;

   logic [REM_W-1:0]       rem_acc, rem_len;
   logic [2:0]             vc_len;
   logic                   vc_room;
   logic [15:0]            tsize_full, rc_inc, id_shift, tstart_new;
   logic [LW-1:0]          idx_inc;
   logic [KW-1:0]          tot_known;
   logic [1:0]             qos_cur;
   logic                   pub_cur, ack_cur, k_is_id_pos, in_tail;

   assign qos_cur     = first_ff[2:1];
   assign pub_cur     = (first_ff[7:4] == TYPE_PUBLISH);
   assign ack_cur     = is_ack_type(first_ff[7:4]);
   assign vc_room     = (vc_ff < MAX_VC);
   assign vc_len      = vc_room ? vc_ff + 3'd1 : vc_ff;
   assign rem_len     = vc_room ? rem_acc : rem_ff;
   assign tsize_full  = tsize_ff | {8'h00, data_byte};
   assign rc_inc      = rc_ff + 16'd1;
   assign id_shift    = {id_ff[7:0], data_byte};
   assign idx_inc     = LW'(idx_ff) + LW'(1);
   assign tstart_new  = 16'(idx_inc);
   assign tot_known   = KW'(rem_ff) + KW'(vc_ff) + KW'(1);
   assign k_is_id_pos = (idx_ff == OFFSET_BITS'(2)) || (idx_ff == OFFSET_BITS'(3));
   assign in_tail     = (phase_ff == PH_TLEN_HI) || (phase_ff == PH_TLEN_LO) ||
                        (phase_ff == PH_TOPIC) || (phase_ff == PH_ID) ||
                        (phase_ff == PH_BODY);

   // Seven-bit group of the length field lands at the position of its count.
   always_comb begin
      rem_acc = rem_ff;
      for (int j = 0; j < MAX_VARINT_BYTES; j++) begin
         if (vc_ff == 3'(j)) begin
            rem_acc = rem_ff | (REM_W'(data_byte[6:0]) << (7 * j));
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_st = phase_ff;
      case (phase_ff)
         PH_FIRST: begin
            phase_st = PH_LEN;
         end
         PH_LEN: begin
            if (!data_byte[7]) begin
               phase_st = pub_cur ? PH_TLEN_HI : PH_BODY;
            end else if (vc_len >= MAX_VC) begin
               phase_st = PH_BAD;
            end
         end
         PH_TLEN_HI: begin
            phase_st = PH_TLEN_LO;
         end
         PH_TLEN_LO: begin
            if (tsize_full != 16'd0) begin
               phase_st = PH_TOPIC;
            end else begin
               phase_st = (qos_cur != 2'd0) ? PH_ID : PH_BODY;
            end
         end
         PH_TOPIC: begin
            if (rc_inc >= tsize_ff) begin
               phase_st = (qos_cur != 2'd0) ? PH_ID : PH_BODY;
            end
         end
         PH_ID: begin
            if (rc_inc >= 16'd2) begin
               phase_st = PH_BODY;
            end
         end
         PH_BODY: begin
            phase_st = PH_BODY;
         end
         default: begin
            phase_st = PH_BAD;
         end
      endcase
   end

   // Field updates and the byte's region tag.
   always_comb begin
      first_st  = first_ff;
      rem_st    = rem_ff;
      vc_st     = vc_ff;
      tsize_st  = tsize_ff;
      tstart_st = tstart_ff;
      rc_st     = rc_ff;
      id_st     = id_ff;
      lob_st    = lob_ff;
      region_st = REGION_BEYOND;
      case (phase_ff)
         PH_FIRST: begin
            first_st  = data_byte;
            rem_st    = '0;
            vc_st     = 3'd0;
            tsize_st  = 16'd0;
            tstart_st = 16'd0;
            rc_st     = 16'd0;
            id_st     = 16'd0;
            lob_st    = 1'b0;
            region_st = REGION_HEADER;
         end
         PH_LEN: begin
            region_st = REGION_LENGTH;
            rem_st    = rem_len;
            vc_st     = vc_len;
            if (!data_byte[7]) begin
               lob_st = (vc_len == 3'd1);
            end
         end
         PH_TLEN_HI: begin
            region_st = REGION_TOPIC_LEN;
            tsize_st  = {data_byte, 8'h00};
         end
         PH_TLEN_LO: begin
            region_st = REGION_TOPIC_LEN;
            tsize_st  = tsize_full;
            tstart_st = tstart_new;
            rc_st     = 16'd0;
         end
         PH_TOPIC: begin
            region_st = REGION_TOPIC;
            rc_st     = (rc_inc >= tsize_ff) ? 16'd0 : rc_inc;
         end
         PH_ID: begin
            region_st = REGION_PACKET_ID;
            id_st     = id_shift;
            rc_st     = rc_inc;
         end
         PH_BODY: begin
            region_st = REGION_PAYLOAD;
            if (!pub_cur && k_is_id_pos) begin
               id_st = id_shift;
               if (ack_cur && lob_ff) begin
                  region_st = REGION_PACKET_ID;
               end
            end
         end
         default: begin
            region_st = REGION_BEYOND;
         end
      endcase
      // After the length field, bytes past the declared packet length are tagged as beyond.
      if (in_tail && (KW'(idx_ff) >= tot_known)) begin
         region_st = REGION_BEYOND;
      end
   end

   // The last byte of a buffer sends the tracker back to a fresh packet.
   always_comb begin
      if (last_byte) begin
         idx_in    = '0;
         first_in  = 8'h00;
         phase_in  = PH_FIRST;
         rem_in    = '0;
         vc_in     = 3'd0;
         tsize_in  = 16'd0;
         tstart_in = 16'd0;
         rc_in     = 16'd0;
         id_in     = 16'd0;
         lob_in    = 1'b0;
      end else begin
         idx_in    = (idx_ff != '1) ? idx_inc[OFFSET_BITS-1:0] : idx_ff;
         first_in  = first_st;
         phase_in  = phase_st;
         rem_in    = rem_st;
         vc_in     = vc_st;
         tsize_in  = tsize_st;
         tstart_in = tstart_st;
         rc_in     = rc_st;
         id_in     = id_st;
         lob_in    = lob_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         first_ff  <= 8'h00;
         phase_ff  <= PH_FIRST;
         rem_ff    <= '0;
         vc_ff     <= 3'd0;
         tsize_ff  <= 16'd0;
         tstart_ff <= 16'd0;
         rc_ff     <= 16'd0;
         id_ff     <= 16'd0;
         lob_ff    <= 1'b0;
      end else if (ctl.take) begin
         idx_ff    <= idx_in;
         first_ff  <= first_in;
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         vc_ff     <= vc_in;
         tsize_ff  <= tsize_in;
         tstart_ff <= tstart_in;
         rc_ff     <= rc_in;
         id_ff     <= id_in;
         lob_ff    <= lob_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         snap_ff.region <= region_st;
         snap_ff.last   <= last_byte;
         snap_ff.first  <= first_st;
         snap_ff.phase  <= phase_st;
         snap_ff.rem    <= rem_st;
         snap_ff.vc     <= vc_st;
         snap_ff.tsize  <= tsize_st;
         snap_ff.tstart <= tstart_st;
         snap_ff.id     <= id_st;
         snap_ff.lob    <= lob_st;
         len_ff         <= idx_inc;
      end
   end

   assign snap    = snap_ff;
   assign buf_len = len_ff;

endmodule

@@ rtl/mqttp_sum.sv @@
`timescale 1ns / 1ps

module mqttp_sum import mqttp_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                 clock,
   input  pipe_ctl_type         ctl,
   input  snap_type             snap,
   input  logic [OFFSET_BITS:0] buf_len,
   output logic [2:0]           byte_region,
   output logic                 done_res,
   output logic [3:0]           msg_type,
   output logic [1:0]           qos_level,
   output logic [28:0]          total_length,
   output logic [15:0]          topic_offset,
   output logic [15:0]          topic_length,
   output logic [15:0]          packet_id,
   output logic [15:0]          payload_offset,
   output logic [15:0]          payload_length,
   output logic [2:0]           parse_status
);

   localparam int CW = (OFFSET_BITS + 2 > 30) ? OFFSET_BITS + 2 : 30;

   // Middle stage: header end, total length and the running byte positions.
   logic          hdr_known;
   logic [CW-1:0] hdr_end, total_c, i_c, itl_c, pos2_c, len_c;
   mid_type       mid_c;

   mid_type       mid_ff;
   logic [CW-1:0] s2_total_ff, s2_i_ff, s2_itl_ff, s2_pos2_ff, s2_len_ff;

   assign hdr_known = (snap.phase != PH_FIRST) && (snap.phase != PH_LEN);
   assign len_c     = CW'(buf_len);
   assign hdr_end   = hdr_known ? CW'(snap.vc) + CW'(1) : len_c;
   assign total_c   = CW'(snap.rem) + hdr_end;
   assign i_c       = hdr_end + CW'(2);
   assign itl_c     = hdr_end + CW'(2) + CW'(snap.tsize);
   assign pos2_c    = hdr_end + CW'(4) + CW'(snap.tsize);

   always_comb begin
      mid_c.region   = snap.region;
      mid_c.last     = snap.last;
      mid_c.bad      = (snap.phase == PH_BAD);
      mid_c.pub      = (snap.first[7:4] == TYPE_PUBLISH);
      mid_c.qos      = snap.first[2:1];
      mid_c.msg_type = snap.first[7:4];
      mid_c.tstart   = snap.tstart;
      mid_c.tsize    = snap.tsize;
      mid_c.id       = snap.id;
      mid_c.ack_ok   = is_ack_type(snap.first[7:4]) && (len_c >= CW'(4)) && snap.lob;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         mid_ff      <= mid_c;
         s2_total_ff <= total_c;
         s2_i_ff     <= i_c;
         s2_itl_ff   <= itl_c;
         s2_pos2_ff  <= pos2_c;
         s2_len_ff   <= len_c;
      end
   end

   // Final stage: truncation checks and field selection.
   logic          q_nz, topic_bad, pay_room, id_fits, pay_ok;
   logic [CW-1:0] pos;
   logic [15:0]   span;

   logic [2:0]  region_ff, status_ff, status_in;
   logic        done_ff;
   logic [3:0]  type_ff, type_in;
   logic [1:0]  qos_ff, qos_in;
   logic [28:0] total_ff, total_in;
   logic [15:0] toff_ff, toff_in, tlen_ff, tlen_in, pid_ff, pid_in;
   logic [15:0] poff_ff, poff_in, plen_ff, plen_in;

   assign q_nz      = (mid_ff.qos != 2'd0);
   assign topic_bad = (s2_i_ff >= s2_len_ff) || (s2_itl_ff > s2_len_ff);
   assign pay_room  = (s2_itl_ff < s2_len_ff);
   assign id_fits   = (s2_pos2_ff < s2_len_ff);
   assign pos       = q_nz ? s2_pos2_ff : s2_itl_ff;
   assign pay_ok    = pay_room && (!q_nz || id_fits) && (s2_total_ff >= pos);
   assign span      = (s2_total_ff <= s2_len_ff) ? s2_total_ff[15:0] : s2_len_ff[15:0];

   always_comb begin
      type_in   = 4'd0;
      qos_in    = 2'd0;
      total_in  = 29'd0;
      toff_in   = 16'd0;
      tlen_in   = 16'd0;
      pid_in    = 16'd0;
      poff_in   = 16'd0;
      plen_in   = 16'd0;
      status_in = STATUS_OK;
      if (mid_ff.last) begin
         type_in  = mid_ff.msg_type;
         qos_in   = mid_ff.qos;
         total_in = s2_total_ff[28:0];
         if (mid_ff.bad) begin
            status_in = STATUS_MALFORMED;
         end else if (!mid_ff.pub) begin
            status_in = STATUS_NOT_PUBLISH;
            if (mid_ff.ack_ok) begin
               pid_in = mid_ff.id;
            end
         end else if (topic_bad) begin
            status_in = STATUS_TOPIC_TRUNC;
         end else begin
            toff_in = mid_ff.tstart;
            tlen_in = mid_ff.tsize;
            if (pay_room && q_nz && id_fits) begin
               pid_in = mid_ff.id;
            end
            if (pay_ok) begin
               status_in = STATUS_OK;
               poff_in   = pos[15:0];
               plen_in   = span - pos[15:0];
            end else begin
               status_in = STATUS_PAYLOAD_TRUNC;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s3) begin
         region_ff <= mid_ff.region;
         done_ff   <= mid_ff.last;
         type_ff   <= type_in;
         qos_ff    <= qos_in;
         total_ff  <= total_in;
         toff_ff   <= toff_in;
         tlen_ff   <= tlen_in;
         pid_ff    <= pid_in;
         poff_ff   <= poff_in;
         plen_ff   <= plen_in;
         status_ff <= status_in;
      end
   end

   assign byte_region    = region_ff;
   assign done_res       = done_ff;
   assign msg_type       = type_ff;
   assign qos_level      = qos_ff;
   assign total_length   = total_ff;
   assign topic_offset   = toff_ff;
   assign topic_length   = tlen_ff;
   assign packet_id      = pid_ff;
   assign payload_offset = poff_ff;
   assign payload_length = plen_ff;
   assign parse_status   = status_ff;

endmodule

@@ rtl/mqtt_packet_field_parser_top.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Beat contents
// req     | in        | req_valid/req_ready  | req_data_byte, req_last_byte
// rsp     | out       | rsp_valid/rsp_ready  | rsp_byte_region, rsp_done_res and the summary
//
// One beat is taken every cycle while rsp_ready is high. A request beat passes
// three register stages (tracker, position sums, checks/select); its response
// beat is shown once the third stage has loaded it.
// Reset is synchronous and active high; it empties the pipeline and returns the
// tracker to waiting for the first byte of a packet.
// When rsp_ready is low, full stages hold while empty ones fill; req_ready
// drops once all three are full; stages behind a taken output keep moving.
module mqtt_packet_field_parser_top import mqttp_pkg::*; #(
   parameter int MAX_VARINT_BYTES = 4,
   parameter int OFFSET_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_byte_region,
   output logic        rsp_done_res,
   output logic [3:0]  rsp_msg_type,
   output logic [1:0]  rsp_qos_level,
   output logic [28:0] rsp_total_length,
   output logic [15:0] rsp_topic_offset,
   output logic [15:0] rsp_topic_length,
   output logic [15:0] rsp_packet_id,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length,
   output logic [2:0]  rsp_parse_status
);

   // Valid bits of the three stages. A stage may load when it is empty or
   // when the stage ahead of it loads in the same cycle.
   logic         v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic         en1, en2, en3;
   pipe_ctl_type ctl;

   snap_type               snap;
   logic [OFFSET_BITS:0]   buf_len;

   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v3_ff;

   assign ctl.take    = req_valid && en1;
   assign ctl.load_s1 = en1;
   assign ctl.load_s2 = en2;
   assign ctl.load_s3 = en3;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Byte tracker: follows the packet layout and captures the state each
   // byte leaves behind, before the end-of-buffer clear.
   mqttp_track #(
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
      .OFFSET_BITS      (OFFSET_BITS)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .snap      (snap),
      .buf_len   (buf_len)
   );

   // Summary: header end and byte positions, then truncation checks and the
   // response register.
   mqttp_sum #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_sum (
      .clock          (clock),
      .ctl            (ctl),
      .snap           (snap),
      .buf_len        (buf_len),
      .byte_region    (rsp_byte_region),
      .done_res       (rsp_done_res),
      .msg_type       (rsp_msg_type),
      .qos_level      (rsp_qos_level),
      .total_length   (rsp_total_length),
      .topic_offset   (rsp_topic_offset),
      .topic_length   (rsp_topic_length),
      .packet_id      (rsp_packet_id),
      .payload_offset (rsp_payload_offset),
      .payload_length (rsp_payload_length),
      .parse_status   (rsp_parse_status)
   );

endmodule

@@ rtl/mqttp_check.sv @@
`timescale 1ns / 1ps

module mqttp_check import mqttp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_byte_region,
   input logic        rsp_done_res,
   input logic [3:0]  rsp_msg_type,
   input logic [1:0]  rsp_qos_level,
   input logic [28:0] rsp_total_length,
   input logic [15:0] rsp_topic_offset,
   input logic [15:0] rsp_topic_length,
   input logic [15:0] rsp_packet_id,
   input logic [15:0] rsp_payload_offset,
   input logic [15:0] rsp_payload_length,
   input logic [2:0]  rsp_parse_status
);

   // Beats that are not the end of a buffer carry only the region tag.
   a_mid_packet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_msg_type == 4'd0 && rsp_qos_level == 2'd0 && rsp_total_length == 29'd0 &&
         rsp_topic_offset == 16'd0 && rsp_topic_length == 16'd0 &&
         rsp_packet_id == 16'd0 && rsp_payload_offset == 16'd0 &&
         rsp_payload_length == 16'd0 && rsp_parse_status == STATUS_OK)
      else $error("summary fields set on a beat that does not end a buffer");

   // Payload position is reported only for a complete publish.
   a_payload_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_status != STATUS_OK |->
         rsp_payload_offset == 16'd0 && rsp_payload_length == 16'd0)
      else $error("payload fields set without a complete publish");

   // Topic fields need a publish whose topic fits in the buffer.
   a_topic_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status == STATUS_TOPIC_TRUNC ||
                    rsp_parse_status == STATUS_NOT_PUBLISH ||
                    rsp_parse_status == STATUS_MALFORMED) |->
         rsp_topic_offset == 16'd0 && rsp_topic_length == 16'd0)
      else $error("topic fields set without a complete topic");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_byte_region) && $stable(rsp_done_res) &&
         $stable(rsp_total_length) && $stable(rsp_packet_id) &&
         $stable(rsp_parse_status))
      else $error("response beat changed while stalled");

endmodule

bind mqtt_packet_field_parser_top mqttp_check u_check (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps

// Stand-alone bench for the MQTT packet field parser. Received buffers are fed
// one byte per beat on the req channel. Every accepted beat is run through a
// byte tracker kept in this file, and the response it should cause is queued.
// Each response beat is then compared field by field with the oldest queued
// response. Both channels idle at random, and the receiver holds off once for a
// long stretch so that the pipeline fills and pushes back on the sender.
module tb;
   import mqttp_pkg::*;

   // Length field limit, index saturation point and run bounds.
   localparam int           MAX_LEN_BYTES   = 4;
   localparam logic [15:0]  INDEX_CAP       = 16'hFFFF;
   localparam int           RANDOM_BEATS    = 1950;
   localparam int           PRESSURE_CYCLES = 300;
   localparam int           DRAIN_CYCLES    = 16;
   localparam int           MAX_REPORTS     = 200;
   localparam longint       CYCLE_LIMIT     = 2000000;

   // One request beat as it waits in the send queue. A buffer marked no_gaps
   // is sent without sender idling.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      bit         no_gaps;
   } req_beat_type;

   // One response beat, with the same fields as the rsp channel.
   typedef struct packed {
      logic [2:0]  region;
      logic        done;
      logic [3:0]  mtype;
      logic [1:0]  qos;
      logic [28:0] total;
      logic [15:0] toff;
      logic [15:0] tlen;
      logic [15:0] pid;
      logic [15:0] poff;
      logic [15:0] plen;
      logic [2:0]  status;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_byte_region;
   logic        rsp_done_res;
   logic [3:0]  rsp_msg_type;
   logic [1:0]  rsp_qos_level;
   logic [28:0] rsp_total_length;
   logic [15:0] rsp_topic_offset;
   logic [15:0] rsp_topic_length;
   logic [15:0] rsp_packet_id;
   logic [15:0] rsp_payload_offset;
   logic [15:0] rsp_payload_length;
   logic [2:0]  rsp_parse_status;

   mqtt_packet_field_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_region    (rsp_byte_region),
      .rsp_done_res       (rsp_done_res),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_qos_level      (rsp_qos_level),
      .rsp_total_length   (rsp_total_length),
      .rsp_topic_offset   (rsp_topic_offset),
      .rsp_topic_length   (rsp_topic_length),
      .rsp_packet_id      (rsp_packet_id),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_parse_status   (rsp_parse_status)
   );

   always #2 clock = ~clock;

   // Queues: bytes of the buffer under construction, beats not yet offered, and
   // responses owed by the block in acceptance order.
   logic [7:0]   pkt_buf[$];
   req_beat_type pending_beats[$];
   rsp_beat_type expected_rsp[$];

   req_beat_type next_beat;
   rsp_beat_type want;
   bit         req_taken = 1'b0;
   bit         pressure_done = 1'b0;
   int         send_gap = 0;
   int         hold_left = 0;
   int         beats_total = 0;
   int         beats_sent = 0;
   int         beats_taken = 0;
   int         rsp_checked = 0;
   int         error_count = 0;
   int         buffer_count = 0;
   int         longest_buffer = 0;
   longint     cycle_count = 0;

   // Byte tracker of the predictor. It mirrors the block's state: position in
   // the buffer, first byte, parse phase, decoded remaining length and its byte
   // count, topic size and start, a counter inside topic and id, the id value
   // and whether the length field was a single byte.
   logic [15:0] trk_index;
   logic [7:0]  trk_first;
   phase_type   trk_phase;
   logic [27:0] trk_remlen;
   logic [2:0]  trk_vcount;
   logic [15:0] trk_tsize;
   logic [15:0] trk_tstart;
   logic [15:0] trk_count;
   logic [15:0] trk_id;
   logic        trk_onebyte;

   function automatic void clear_tracker();
      trk_index   = '0;
      trk_first   = '0;
      trk_phase   = PH_FIRST;
      trk_remlen  = '0;
      trk_vcount  = '0;
      trk_tsize   = '0;
      trk_tstart  = '0;
      trk_count   = '0;
      trk_id      = '0;
      trk_onebyte = 1'b0;
   endfunction

   // Acknowledgement types carry their packet id in bytes two and three.
   function automatic logic acks_with_id(input logic [3:0] t);
      return ((t >= TYPE_PUBACK) && (t <= TYPE_SUBACK)) || (t == TYPE_UNSUBACK);
   endfunction

   // Advances the tracker by one byte and returns the response it causes. On
   // the last byte of a buffer the packet summary is filled in and the tracker
   // goes back to waiting for a first byte.
   function automatic rsp_beat_type predict_response(input logic [7:0] b, input logic last);
      rsp_beat_type    r;
      phase_type       entry;
      logic            pub;
      logic            ok;
      logic [1:0]      q;
      logic [3:0]      ptype;
      logic [2:0]      region;
      logic [2:0]      status;
      logic [15:0]     pid;
      longint unsigned k, tot_known, total, h, i, pos, blen;
      longint unsigned t_off, t_len, p_off, p_len;

      k         = trk_index;
      entry     = trk_phase;
      q         = trk_first[2:1];
      pub       = (trk_first[7:4] == TYPE_PUBLISH);
      tot_known = 64'(trk_remlen) + 64'(trk_vcount) + 1;
      region    = REGION_BEYOND;

      case (entry)
         PH_FIRST: begin
            clear_tracker();
            trk_first = b;
            trk_phase = PH_LEN;
            region    = REGION_HEADER;
         end
         PH_LEN: begin
            region = REGION_LENGTH;
            if (trk_vcount < MAX_LEN_BYTES) begin
               trk_remlen = trk_remlen | (28'(b[6:0]) << (7 * trk_vcount));
               trk_vcount = trk_vcount + 3'd1;
            end
            if (!b[7]) begin
               trk_onebyte = (trk_vcount == 3'd1);
               if (pub) trk_phase = PH_TLEN_HI;
               else trk_phase = PH_BODY;
            end else if (trk_vcount >= MAX_LEN_BYTES) begin
               trk_phase = PH_BAD;
            end
         end
         PH_TLEN_HI: begin
            region    = REGION_TOPIC_LEN;
            trk_tsize = {b, 8'h00};
            trk_phase = PH_TLEN_LO;
         end
         PH_TLEN_LO: begin
            region     = REGION_TOPIC_LEN;
            trk_tsize  = trk_tsize | 16'(b);
            trk_tstart = 16'(k + 1);
            trk_count  = '0;
            if (trk_tsize != 0) trk_phase = PH_TOPIC;
            else if (q != 0) trk_phase = PH_ID;
            else trk_phase = PH_BODY;
         end
         PH_TOPIC: begin
            region    = REGION_TOPIC;
            trk_count = trk_count + 16'd1;
            if (trk_count >= trk_tsize) begin
               trk_count = '0;
               if (q != 0) trk_phase = PH_ID;
               else trk_phase = PH_BODY;
            end
         end
         PH_ID: begin
            region    = REGION_PACKET_ID;
            trk_id    = {trk_id[7:0], b};
            trk_count = trk_count + 16'd1;
            if (trk_count >= 2) trk_phase = PH_BODY;
         end
         PH_BODY: begin
            region = REGION_PAYLOAD;
            if (!pub && (k == 2 || k == 3)) begin
               trk_id = {trk_id[7:0], b};
               if (acks_with_id(trk_first[7:4]) && trk_onebyte) region = REGION_PACKET_ID;
            end
         end
         default: region = REGION_BEYOND;
      endcase
      if (entry >= PH_TLEN_HI && entry <= PH_BODY && k >= tot_known) region = REGION_BEYOND;

      r        = '0;
      r.region = region;
      if (!last) begin
         if (trk_index < INDEX_CAP) trk_index = trk_index + 16'd1;
         return r;
      end

      blen   = k + 1;
      ptype  = trk_first[7:4];
      r.done = 1'b1;
      r.mtype = ptype;
      r.qos  = trk_first[2:1];
      status = STATUS_NOT_PUBLISH;
      pid    = '0;
      t_off  = 0;
      t_len  = 0;
      p_off  = 0;
      p_len  = 0;
      if (trk_phase == PH_BAD) begin
         total  = 64'(trk_remlen) + 64'(trk_vcount) + 1;
         status = STATUS_MALFORMED;
      end else begin
         // The header ends after the length field, or at the buffer end if the
         // length field never finished.
         h     = (trk_phase >= PH_TLEN_HI) ? 64'(trk_vcount) + 1 : blen;
         total = 64'(trk_remlen) + h;
         if (ptype == TYPE_PUBLISH) begin
            i = h + 2;
            if (i >= blen || i + trk_tsize > blen) begin
               status = STATUS_TOPIC_TRUNC;
            end else begin
               t_off  = trk_tstart;
               t_len  = trk_tsize;
               status = STATUS_PAYLOAD_TRUNC;
               if (i + trk_tsize < blen) begin
                  pos = i + trk_tsize;
                  ok  = 1'b1;
                  if (r.qos != 0) begin
                     if (pos + 2 < blen) pid = trk_id;
                     else ok = 1'b0;
                     pos = pos + 2;
                  end
                  if (ok && total >= pos) begin
                     status = STATUS_OK;
                     p_off  = pos;
                     p_len  = ((total <= blen) ? total : blen) - pos;
                  end
               end
            end
         end else if (acks_with_id(ptype) && blen >= 4 && trk_onebyte) begin
            pid = trk_id;
         end
      end
      r.total  = total[28:0];
      r.toff   = t_off[15:0];
      r.tlen   = t_len[15:0];
      r.pid    = pid;
      r.poff   = p_off[15:0];
      r.plen   = p_len[15:0];
      r.status = status;
      clear_tracker();
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Buffer construction. Bytes collect in pkt_buf and are then moved to the
   // send queue, with the last-byte flag on the final one.
   // ---------------------------------------------------------------------
   task automatic flush_packet(input bit no_gaps);
      foreach (pkt_buf[n])
         pending_beats.push_back('{data: pkt_buf[n], last: (n == pkt_buf.size() - 1),
                                   no_gaps: no_gaps});
      buffer_count++;
      if (pkt_buf.size() > longest_buffer) longest_buffer = pkt_buf.size();
      pkt_buf.delete();
   endtask

   function automatic int min_varint(input int unsigned v);
      if (v < 128) return 1;
      if (v < 16384) return 2;
      if (v < 2097152) return 3;
      return 4;
   endfunction

   // Writes v as a length field of nb bytes; more bytes than needed give a
   // padded encoding that still decodes to v.
   task automatic add_varint(input int unsigned v, input int nb);
      for (int n = 0; n < nb; n++) begin
         pkt_buf.push_back({(n < nb - 1), v[6:0]});
         v = v >> 7;
      end
   endtask

   task automatic add_random(input int count);
      repeat (count) pkt_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // Most buffers hold the packet exactly; some are cut short and some carry
   // trailing bytes past the packet's own length.
   task automatic shape_buffer();
      int s;
      int cut;
      s = $urandom_range(0, 9);
      if (s < 2 && pkt_buf.size() > 1) begin
         cut = $urandom_range(1, pkt_buf.size() - 1);
         while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
      end else if (s == 2) begin
         add_random($urandom_range(1, 5));
      end
   endtask

   // A PUBLISH with random content. Now and then the remaining length is off,
   // the length field is padded, or the topic length field is random.
   task automatic make_publish();
      int qos, tlen, plen, rem, nb, tfield, v;
      qos  = $urandom_range(0, 3);
      tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      plen = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 180) : $urandom_range(0, 12);
      rem  = 2 + tlen + ((qos != 0) ? 2 : 0) + plen;
      v    = $urandom_range(0, 11);
      if (v == 0) begin
         rem = rem + $urandom_range(0, 6) - 3;
         if (rem < 0) rem = 0;
      end
      nb = min_varint(rem);
      if (v == 1 && nb < MAX_LEN_BYTES) nb++;
      tfield = (v == 2) ? $urandom_range(0, 65535) : tlen;
      pkt_buf.push_back({TYPE_PUBLISH, 1'($urandom_range(0, 1)), 2'(qos),
                         1'($urandom_range(0, 1))});
      add_varint(rem, nb);
      pkt_buf.push_back(tfield[15:8]);
      pkt_buf.push_back(tfield[7:0]);
      add_random(tlen + ((qos != 0) ? 2 : 0) + plen);
      shape_buffer();
      flush_packet(1'b0);
   endtask

   // An acknowledgement, mostly with the usual two-byte id body.
   task automatic make_ack();
      logic [3:0] t;
      int         rem, nb;
      t = 4'($urandom_range(TYPE_PUBACK, TYPE_SUBACK + 1));
      if (t == TYPE_SUBACK + 1) t = TYPE_UNSUBACK;
      rem = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 2;
      nb  = ($urandom_range(0, 5) == 0) ? 2 : 1;
      pkt_buf.push_back({t, 4'($urandom_range(0, 15))});
      add_varint(rem, nb);
      add_random(rem);
      shape_buffer();
      flush_packet(1'b0);
   endtask

   task automatic make_other();
      int rem;
      rem = $urandom_range(0, 10);
      pkt_buf.push_back(8'($urandom_range(0, 255)));
      add_varint(rem, min_varint(rem));
      add_random(rem);
      shape_buffer();
      flush_packet(1'b0);
   endtask

   // Four length bytes that all ask for more, then a few stray bytes.
   task automatic make_malformed();
      pkt_buf.push_back(8'($urandom_range(0, 255)));
      repeat (MAX_LEN_BYTES) pkt_buf.push_back({1'b1, 7'($urandom_range(0, 127))});
      add_random($urandom_range(0, 4));
      flush_packet(1'b0);
   endtask

   // Sender idling: mostly none or short, a few long gaps, and windows with
   // no idling at all.
   function automatic int pick_gap();
      int r;
      if ((beats_sent % 500) < 120) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_stall();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned got_v);
      if (exp_v !== got_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch on response %0d, expected %0d, got %0d",
                     $time, name, rsp_checked, exp_v, got_v);
         else if (error_count == MAX_REPORTS + 1)
            $display("%0t ns: further mismatches are counted without detail", $time);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and run control.
   // ---------------------------------------------------------------------
   initial begin
      int start_beats;
      int kind;

      clear_tracker();

      // A buffer of one byte: a PUBLISH that ends at its first byte.
      pkt_buf.push_back({TYPE_PUBLISH, 4'h0});
      flush_packet(1'b0);
      // Acknowledgement ids, one ordinary and one all ones.
      pkt_buf = '{{TYPE_PUBACK, 4'h0}, 8'h02, 8'h12, 8'h34};
      flush_packet(1'b0);
      pkt_buf = '{{TYPE_UNSUBACK, 4'h0}, 8'h02, 8'hFF, 8'hFF};
      flush_packet(1'b0);
      // A length field whose fourth byte still asks for more.
      pkt_buf = '{{TYPE_PUBLISH, 4'h2}, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
      flush_packet(1'b0);
      // The largest remaining length, on the largest type and QoS.
      pkt_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
      flush_packet(1'b0);
      // A complete QoS 1 PUBLISH with a one-byte topic and two payload bytes,
      // sent back to back.
      pkt_buf = '{{TYPE_PUBLISH, 4'h2}, 8'h07, 8'h00, 8'h01, 8'h61, 8'hAB, 8'hCD,
                  8'h00, 8'hFF};
      flush_packet(1'b1);

      // Random part: mostly well-formed packets with random content, the rest
      // odd types, broken length fields and plain noise.
      start_beats = pending_beats.size();
      while (pending_beats.size() - start_beats < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) make_publish();
         else if (kind < 75) make_ack();
         else if (kind < 85) make_other();
         else if (kind < 92) make_malformed();
         else begin
            add_random($urandom_range(1, 12));
            flush_packet(1'b0);
         end
      end
      beats_total = pending_beats.size();

      // Synchronous reset, released on a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every beat is in and every owed response is out, then give
      // the pipeline a few more cycles to show any response it should not send.
      while (beats_taken != beats_total || expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d beats in %0d buffers (longest %0d bytes), %0d responses checked",
               beats_taken, buffer_count, longest_buffer, rsp_checked);
      $display("summary: %0d mismatches, one receiver hold of %0d cycles, %0d cycles run",
               error_count, PRESSURE_CYCLES, cycle_count);
      if (error_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   // Driver. Changes the req side on the falling edge. A beat is held until the
   // monitor has seen it accepted; then either a gap starts or the next beat
   // goes out at once, so valid is never dropped and raised in one step.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Still waiting for the current beat to be accepted.
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_beats.size() > 0) begin
         next_beat = pending_beats.pop_front();
         req_valid     <= 1'b1;
         req_data_byte <= next_beat.data;
         req_last_byte <= next_beat.last;
         beats_sent++;
         if (pending_beats.size() > 0 && pending_beats[0].no_gaps) send_gap = 0;
         else send_gap = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver. Drives rsp_ready on the falling edge with random stalls, runs of
   // steady readiness, and once a long hold so the block backs up into req.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!pressure_done && rsp_checked >= 400) begin
         rsp_ready <= 1'b0;
         hold_left = PRESSURE_CYCLES - 1;
         pressure_done = 1'b1;
      end else if ((rsp_checked % 600) < 150 || $urandom_range(0, 99) < 80) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         hold_left = pick_stall() - 1;
      end
   end

   // Monitor. Samples both channels on the rising edge. An accepted request beat
   // is predicted first, so that the owed response is queued before any
   // response of the same edge is checked.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_response(req_data_byte, req_last_byte));
            req_taken = 1'b1;
            beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               error_count++;
               $display("%0t ns: response beat with nothing owed, region %0d done %0d",
                        $time, rsp_byte_region, rsp_done_res);
            end else begin
               want = expected_rsp.pop_front();
               check_field("byte_region", want.region, rsp_byte_region);
               check_field("done_res", want.done, rsp_done_res);
               check_field("msg_type", want.mtype, rsp_msg_type);
               check_field("qos_level", want.qos, rsp_qos_level);
               check_field("total_length", want.total, rsp_total_length);
               check_field("topic_offset", want.toff, rsp_topic_offset);
               check_field("topic_length", want.tlen, rsp_topic_length);
               check_field("packet_id", want.pid, rsp_packet_id);
               check_field("payload_offset", want.poff, rsp_payload_offset);
               check_field("payload_length", want.plen, rsp_payload_length);
               check_field("parse_status", want.status, rsp_parse_status);
               rsp_checked++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: run stopped after %0d cycles, %0d of %0d beats taken, %0d owed",
                  $time, cycle_count, beats_taken, beats_total, expected_rsp.size());
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule

@@ files.f @@
rtl/mqttp_pkg.sv
rtl/mqttp_track.sv
rtl/mqttp_sum.sv
rtl/mqtt_packet_field_parser_top.sv
rtl/mqttp_check.sv
test/tb.sv
